// ===== hdl/tast_pkg.sv =====
// Package for the timed action schedule table.
// Holds command codes, field widths, the stored entry layout, the result word
// and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package tast_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    localparam int DEVICE_W = 8;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int ACTION_W = 8;
    localparam int SLOT_W   = 8;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_DEL   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_CHECK = 2'd3;

    localparam logic [ACTION_W-1:0] ACT_CLOSE = 8'd0;
    localparam logic [ACTION_W-1:0] ACT_OPEN  = 8'd1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [DEVICE_W-1:0] device;
    } entry_t;

    typedef struct packed {
        logic                last;
        logic [COUNT_W-1:0]  used_count;
        logic                move_up;
        logic                move_down;
        logic [ACTION_W-1:0] action_out;
        logic [MINUTE_W-1:0] minute_out;
        logic [HOUR_W-1:0]   hour_out;
        logic [DEVICE_W-1:0] device_out;
        logic [INDEX_W-1:0]  slot_index;
        logic                ok;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_DEL,
        ST_READ,
        ST_RDATA,
        ST_CHECK,
        ST_FLUSH
    } state_t;

endpackage

// ===== hdl/timed_action_schedule_table.sv =====
// Top level of the timed action schedule table.
// Depends on tast_pkg (types, codes, widths) and tast_ram (entry storage).
`timescale 1ns / 1ps

// Usage
// The input channel (s_) carries one command word: s_tuser holds the command
// (add, delete, read, check) and s_tdata the slot, device, hour, minute and
// action. The result channel (m_) returns result words; m_tlast marks the
// final word of a command. Add, delete and read give one word. Check gives
// one word per used slot whose hour and minute match, in rising slot order,
// or a single word with ok clear when nothing matches.
// Timing: a command is taken only while the sequencer is idle. Add searches
// for the lowest free slot one slot per cycle, and check reads the entry RAM
// one slot per cycle for a single comparator, unless a receiver stall holds
// the scan. The next command is taken in the cycle after the final word is
// loaded. A new command may be accepted while the previous final word still
// waits in the output register.
// Reset clears all used marks and the used count; entry contents are not
// cleared and need no clearing pass, since unused slot data is never output.
// When the receiver stalls, a check scan freezes as soon as a second match
// is waiting behind the output register, so no word is lost.

module timed_action_schedule_table
    import tast_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Input channel.
    input  logic                s_tvalid,
    output logic                s_tready,
    // s_tdata, from bit 0: slot[7:0], device[15:8], hour[20:16],
    // minute[26:21], action[34:27], zero padding.
    input  logic [S_DATA_W-1:0] s_tdata,
    // s_tuser: cmd[1:0].
    input  logic [1:0]          s_tuser,
    // Result channel.
    output logic                m_tvalid,
    input  logic                m_tready,
    // m_tdata, from bit 0: ok[0], slot_index[6:1], device_out[14:7],
    // hour_out[19:15], minute_out[25:20], action_out[33:26], move_down[34],
    // move_up[35], used_count[42:36], zero padding.
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);
    localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(SLOT_COUNT);

    state_t state_reg, state_next;

    // Latched command payload.
    logic [SLOT_W-1:0]   slot_reg;
    logic [DEVICE_W-1:0] dev_reg;
    logic [HOUR_W-1:0]   hour_reg;
    logic [MINUTE_W-1:0] min_reg;
    logic [ACTION_W-1:0] act_reg;

    // Scan sequencer.
    logic [IW-1:0]         idx_reg;
    logic                  iss_done_reg;
    logic                  cmp_vld_reg;
    logic [IW-1:0]         cmp_idx_reg;

    // Table state kept in flip-flops.
    logic [SLOT_COUNT-1:0] mark_reg;
    logic [COUNT_W-1:0]    cnt_reg;

    // One-word holding stage so the last match can be flagged, then output.
    logic pend_vld_reg;
    res_t pend_reg;
    logic m_valid_reg;
    res_t m_res_reg;

    // Entry RAM.
    logic          ram_we;
    logic          ram_re;
    logic [IW-1:0] ram_raddr;
    entry_t        ram_wdata;
    entry_t        ram_rdata;

    logic accept;
    logic out_free;
    logic hit;
    logic stall;
    logic adv;
    logic free_hit;
    logic in_range;
    logic read_ok;
    logic m_load;
    res_t m_word;
    res_t match_word;
    res_t add_word;
    res_t del_word;
    res_t rd_word;

    tast_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign in_range  = slot_reg < SLOT_LIMIT;
    assign ram_wdata = '{action: act_reg, minute: min_reg, hour: hour_reg, device: dev_reg};

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        CMD_ADD:   state_next = ST_ADD;
                        CMD_DEL:   state_next = ST_DEL;
                        CMD_READ:  state_next = ST_READ;
                        CMD_CHECK: state_next = ST_CHECK;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD: begin
                if (free_hit || idx_reg == LAST_IDX) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_DEL:   state_next = ST_FLUSH;
            ST_READ:  state_next = ST_RDATA;
            ST_RDATA: state_next = ST_FLUSH;
            ST_CHECK: begin
                if (iss_done_reg && !cmp_vld_reg) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_tready  = 1'b0;
        hit       = 1'b0;
        stall     = 1'b0;
        adv       = 1'b0;
        free_hit  = 1'b0;
        read_ok   = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = idx_reg;
        m_load    = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_ADD:  free_hit = !mark_reg[idx_reg];
            ST_READ: begin
                ram_re    = 1'b1;
                ram_raddr = slot_reg[IW-1:0];
            end
            ST_RDATA: read_ok = in_range && mark_reg[slot_reg[IW-1:0]];
            ST_CHECK: begin
                hit    = cmp_vld_reg && mark_reg[cmp_idx_reg]
                         && ram_rdata.hour == hour_reg && ram_rdata.minute == min_reg;
                stall  = hit && pend_vld_reg && !out_free;
                adv    = !stall;
                ram_re = adv && !iss_done_reg;
                m_load = hit && pend_vld_reg && out_free;
            end
            ST_FLUSH: m_load = out_free;
            default: ;
        endcase
    end

    assign ram_we = free_hit;

    always_comb begin
        match_word            = '0;
        match_word.ok         = 1'b1;
        match_word.slot_index = INDEX_W'(cmp_idx_reg);
        match_word.device_out = ram_rdata.device;
        match_word.hour_out   = ram_rdata.hour;
        match_word.minute_out = ram_rdata.minute;
        match_word.action_out = ram_rdata.action;
        match_word.move_down  = ram_rdata.action == ACT_CLOSE;
        match_word.move_up    = ram_rdata.action == ACT_OPEN;
    end

    // Result words of add, delete and read, before the count is filled in.
    always_comb begin
        add_word            = '0;
        add_word.ok         = 1'b1;
        add_word.slot_index = INDEX_W'(idx_reg);
        del_word            = '0;
        del_word.ok         = 1'b1;
        del_word.slot_index = slot_reg[INDEX_W-1:0];
        rd_word             = del_word;
        rd_word.device_out  = ram_rdata.device;
        rd_word.hour_out    = ram_rdata.hour;
        rd_word.minute_out  = ram_rdata.minute;
        rd_word.action_out  = ram_rdata.action;
    end

    // Word handed to the output register: the held word, or an empty final
    // word when a check found nothing (or an add, delete or read failed).
    always_comb begin
        m_word = pend_vld_reg ? pend_reg : '0;
        m_word.used_count = cnt_reg;
        m_word.last       = (state_reg == ST_FLUSH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mark_reg     <= '0;
            cnt_reg      <= '0;
            iss_done_reg <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (accept) begin
                slot_reg     <= s_tdata[7:0];
                dev_reg      <= s_tdata[15:8];
                hour_reg     <= s_tdata[20:16];
                min_reg      <= s_tdata[26:21];
                act_reg      <= s_tdata[34:27];
                idx_reg      <= '0;
                iss_done_reg <= 1'b0;
                cmp_vld_reg  <= 1'b0;
                pend_vld_reg <= 1'b0;
            end

            case (state_reg)
                ST_ADD: begin
                    if (free_hit) begin
                        mark_reg[idx_reg] <= 1'b1;
                        cnt_reg           <= cnt_reg + 1'b1;
                        pend_reg          <= add_word;
                        pend_vld_reg      <= 1'b1;
                    end else if (idx_reg != LAST_IDX) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DEL: begin
                    if (in_range) begin
                        if (mark_reg[slot_reg[IW-1:0]]) begin
                            cnt_reg <= cnt_reg - 1'b1;
                        end
                        mark_reg[slot_reg[IW-1:0]] <= 1'b0;
                    end
                    pend_reg     <= del_word;
                    pend_vld_reg <= in_range;
                end
                ST_RDATA: begin
                    pend_reg     <= rd_word;
                    pend_vld_reg <= read_ok;
                end
                ST_CHECK: begin
                    if (adv) begin
                        if (!iss_done_reg) begin
                            cmp_vld_reg <= 1'b1;
                            cmp_idx_reg <= idx_reg;
                            if (idx_reg == LAST_IDX) begin
                                iss_done_reg <= 1'b1;
                            end else begin
                                idx_reg <= idx_reg + 1'b1;
                            end
                        end else begin
                            cmp_vld_reg <= 1'b0;
                        end
                        if (hit) begin
                            pend_reg     <= match_word;
                            pend_vld_reg <= 1'b1;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (out_free) begin
                        pend_vld_reg <= 1'b0;
                    end
                end
                default: ;
            endcase

            if (m_load) begin
                m_valid_reg <= 1'b1;
                m_res_reg   <= m_word;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_res_reg.last;
    assign m_tdata  = {5'd0,
                       m_res_reg.used_count,
                       m_res_reg.move_up,
                       m_res_reg.move_down,
                       m_res_reg.action_out,
                       m_res_reg.minute_out,
                       m_res_reg.hour_out,
                       m_res_reg.device_out,
                       m_res_reg.slot_index,
                       m_res_reg.ok};

    // The running count always agrees with the used marks.
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) == $countones(mark_reg))
        else $error("used count differs from the number of used marks");

    // A new word never overwrites one that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_load |-> out_free)
        else $error("output word overwritten before it was taken");

    // Leaving the flush step always presents a final word.
    a_flush_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH && out_free) |=> (m_tvalid && m_tlast))
        else $error("command ended without a final word");

    // A check scan leaves the used count untouched.
    a_check_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |=> $stable(cnt_reg))
        else $error("used count changed during a check scan");

endmodule

// ===== hdl/tast_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// The read data holds while the read enable is low. No dependencies.
`timescale 1ns / 1ps

module tast_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
